@@ sv/clock_date_setting_menu_core_assert.svh @@
// Assertion macros for the checker file of the date setting menu core.
`ifndef CLOCK_DATE_SETTING_MENU_CORE_ASSERT_SVH
`define CLOCK_DATE_SETTING_MENU_CORE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define CDSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cdsm: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define CDSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cdsm: next-cycle check failed");

`endif

@@ sv/cdsm_pkg.sv @@
// Types, codes and helper functions of the date setting menu core.
`timescale 1ns / 1ps

package cdsm_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_COMMIT = 2'd2;

  // Buttons.
  localparam logic [1:0] BTN_UP    = 2'd0;
  localparam logic [1:0] BTN_DOWN  = 2'd1;
  localparam logic [1:0] BTN_RIGHT = 2'd2;
  localparam logic [1:0] BTN_LEFT  = 2'd3;

  // Field indexes.
  localparam logic [2:0] FIELD_SEC     = 3'd0;
  localparam logic [2:0] FIELD_MIN     = 3'd1;
  localparam logic [2:0] FIELD_HOUR    = 3'd2;
  localparam logic [2:0] FIELD_WEEKDAY = 3'd3;
  localparam logic [2:0] FIELD_DAY     = 3'd4;
  localparam logic [2:0] FIELD_MONTH   = 3'd5;
  localparam logic [2:0] FIELD_YEAR    = 3'd6;

  // Field ranges.
  localparam logic [6:0] SEC_MAX     = 7'd59;
  localparam logic [6:0] MIN_MAX     = 7'd59;
  localparam logic [6:0] HOUR_MAX    = 7'd23;
  localparam logic [6:0] WEEKDAY_MIN = 7'd1;
  localparam logic [6:0] WEEKDAY_MAX = 7'd7;
  localparam logic [6:0] DAY_MIN     = 7'd1;
  localparam logic [6:0] MONTH_MIN   = 7'd1;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] ZERO_MIN    = 7'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] button;
    logic [5:0] load_second;
    logic [5:0] load_minute;
    logic [4:0] load_hour;
    logic [2:0] load_weekday;
    logic [4:0] load_day;
    logic [3:0] load_month;
    logic [6:0] load_year;
  } in_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [2:0] field_index;
    logic       write_clock;
  } out_t;

  localparam out_t OUT_RESET = '{
    second: 6'd0, minute: 6'd0, hour: 5'd0, weekday: 3'd1, day: 5'd1,
    month: 4'd1, year: 7'd0, field_index: FIELD_SEC, write_clock: 1'b0
  };

  // Move v by one, then wrap: above hi goes to lo, below lo goes to hi.
  function automatic logic [6:0] step_wrap(input logic [6:0] v, input logic up,
                                           input logic [6:0] lo, input logic [6:0] hi);
    logic signed [8:0] x;
    x = up ? ($signed({2'b00, v}) + 9'sd1) : ($signed({2'b00, v}) - 9'sd1);
    if (x > $signed({2'b00, hi})) x = $signed({2'b00, lo});
    if (x < $signed({2'b00, lo})) x = $signed({2'b00, hi});
    return x[6:0];
  endfunction

  // Days in month m of year y; months out of range count 31.
  function automatic logic [4:0] month_length(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ sv/cdsm_next.sv @@
// Next-state logic of the date setting menu: load, commit and button steps.
`timescale 1ns / 1ps

module cdsm_next (
  input  cdsm_pkg::out_t cur_i,
  input  cdsm_pkg::in_t  item_i,
  output cdsm_pkg::out_t nxt_o
);

  logic       up;
  logic [3:0] mon_step;
  logic [6:0] yr_step;
  logic [4:0] len_cur;
  logic [4:0] len_mon;
  logic [4:0] len_yr;

  assign up       = (item_i.button == cdsm_pkg::BTN_UP);
  assign mon_step = 4'(cdsm_pkg::step_wrap({3'b000, cur_i.month}, up,
                                           cdsm_pkg::MONTH_MIN, cdsm_pkg::MONTH_MAX));
  assign yr_step  = cdsm_pkg::step_wrap(cur_i.year, up, cdsm_pkg::ZERO_MIN,
                                        cdsm_pkg::YEAR_MAX);
  assign len_cur  = cdsm_pkg::month_length(cur_i.month, cur_i.year);
  assign len_mon  = cdsm_pkg::month_length(mon_step, cur_i.year);
  assign len_yr   = cdsm_pkg::month_length(cur_i.month, yr_step);

  always_comb begin
    nxt_o             = cur_i;
    nxt_o.write_clock = 1'b0;
    unique case (item_i.kind)
      cdsm_pkg::KIND_LOAD: begin
        nxt_o.second  = item_i.load_second;
        nxt_o.minute  = item_i.load_minute;
        nxt_o.hour    = item_i.load_hour;
        nxt_o.weekday = item_i.load_weekday;
        nxt_o.day     = item_i.load_day;
        nxt_o.month   = item_i.load_month;
        nxt_o.year    = item_i.load_year;
      end
      cdsm_pkg::KIND_COMMIT: begin
        nxt_o.write_clock = 1'b1;
        nxt_o.field_index = cdsm_pkg::FIELD_SEC;
      end
      cdsm_pkg::KIND_BUTTON: begin
        if (item_i.button == cdsm_pkg::BTN_RIGHT || item_i.button == cdsm_pkg::BTN_LEFT) begin
          nxt_o.field_index = 3'(cdsm_pkg::step_wrap({4'b0000, cur_i.field_index},
                                 item_i.button == cdsm_pkg::BTN_RIGHT,
                                 {4'b0000, cdsm_pkg::FIELD_SEC},
                                 {4'b0000, cdsm_pkg::FIELD_YEAR}));
        end else begin
          case (cur_i.field_index)
            cdsm_pkg::FIELD_SEC: begin
              nxt_o.second = 6'(cdsm_pkg::step_wrap({1'b0, cur_i.second}, up,
                                                    cdsm_pkg::ZERO_MIN, cdsm_pkg::SEC_MAX));
            end
            cdsm_pkg::FIELD_MIN: begin
              nxt_o.minute = 6'(cdsm_pkg::step_wrap({1'b0, cur_i.minute}, up,
                                                    cdsm_pkg::ZERO_MIN, cdsm_pkg::MIN_MAX));
            end
            cdsm_pkg::FIELD_HOUR: begin
              nxt_o.hour = 5'(cdsm_pkg::step_wrap({2'b00, cur_i.hour}, up,
                                                  cdsm_pkg::ZERO_MIN, cdsm_pkg::HOUR_MAX));
            end
            cdsm_pkg::FIELD_WEEKDAY: begin
              nxt_o.weekday = 3'(cdsm_pkg::step_wrap({4'b0000, cur_i.weekday}, up,
                                                     cdsm_pkg::WEEKDAY_MIN,
                                                     cdsm_pkg::WEEKDAY_MAX));
            end
            cdsm_pkg::FIELD_DAY: begin
              nxt_o.day = 5'(cdsm_pkg::step_wrap({2'b00, cur_i.day}, up,
                                                 cdsm_pkg::DAY_MIN, {2'b00, len_cur}));
            end
            cdsm_pkg::FIELD_MONTH: begin
              nxt_o.month = mon_step;
              // clamp the day to the new month's length
              if (cur_i.day > len_mon) nxt_o.day = len_mon;
            end
            cdsm_pkg::FIELD_YEAR: begin
              nxt_o.year = yr_step;
              if (cur_i.day > len_yr) nxt_o.day = len_yr;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/clock_date_setting_menu_core.sv @@
// Top level of the date and time setting menu core.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+-------------------------------
//   in      | sink      | in_valid_i/in_stall_o | cdsm_pkg::in_t  (load/button/commit)
//   out     | source    | out_valid_o/out_stall_i | cdsm_pkg::out_t (fields, index, write)
//
// Each accepted beat produces exactly one result beat, in the cycle after it is accepted.
// One beat per cycle is sustained while out_stall_i is low; the single result register sets that rate.
// Reset sets second/minute/hour/year to 0, weekday/day/month to 1, index to 0,
// and leaves the output empty.
// While a result is held by out_stall_i, in_stall_o is raised; once the result
// is taken, a new beat is accepted in that same cycle.
`timescale 1ns / 1ps

module clock_date_setting_menu_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cdsm_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cdsm_pkg::out_t   out_data_o
);

  // The result register doubles as the menu state: it changes only when a new
  // beat is accepted, which can only happen when the slot is free or draining.
  cdsm_pkg::out_t state_q;
  cdsm_pkg::out_t state_d;
  logic           valid_q;
  logic           in_accept;

  // Stall the input only while an untaken result sits in the register.
  assign in_stall_o = valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  cdsm_next u_next (
    .cur_i  (state_q),
    .item_i (in_data_i),
    .nxt_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdsm_pkg::OUT_RESET;
      valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        // advance the state and present the new result
        state_q <= state_d;
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        // result taken with nothing behind it: drop valid, hold the fields
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = state_q;

endmodule

@@ sv/cdsm_checker.sv @@
// Port-level checker of the date setting menu core, with its bind.
`timescale 1ns / 1ps
`include "clock_date_setting_menu_core_assert.svh"

module cdsm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input cdsm_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input cdsm_pkg::out_t out_data_o
);

  `CDSM_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `CDSM_ASSERT_NOW(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o)
  `CDSM_ASSERT_NOW(a_index_range, clk_i, rst_ni, out_valid_o, out_data_o.field_index <= cdsm_pkg::FIELD_YEAR)
  `CDSM_ASSERT_NOW(a_write_resets_index, clk_i, rst_ni, out_valid_o && out_data_o.write_clock, out_data_o.field_index == cdsm_pkg::FIELD_SEC)
  `CDSM_ASSERT_NEXT(a_commit_result, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_data_i.kind == cdsm_pkg::KIND_COMMIT), out_valid_o && out_data_o.write_clock)

endmodule

bind clock_date_setting_menu_core cdsm_checker u_cdsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
